### hw/rtl/rmst_pkg.sv
// Package: shared widths, codes and structs of the range min/max spread tree.
package rmst_pkg;

    // Field widths on the channels
    localparam int KIND_W   = 1;
    localparam int INDEX_W  = 10;
    localparam int PRICE_W  = 17;
    localparam int SPREAD_W = 17;
    localparam int CFG_W    = 11;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 17;

    // Reset value of the entries-in-use register
    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(1024);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SET   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    // One request as seen by the sequencer
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] last_index;
        logic [PRICE_W-1:0] price;
    } t_cmd;

    // One query result
    typedef struct packed {
        logic [SPREAD_W-1:0] spread;
        logic                range_error;
    } t_result;

endpackage

### hw/rtl/rmst_ifs.sv
// Interfaces: request, result and configuration channels with valid/ready.
interface rmst_req_if;
    import rmst_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  last_index;
    logic [PRICE_W-1:0]  price;

    modport source (output valid, kind, first_index, last_index, price, input ready);
    modport sink   (input valid, kind, first_index, last_index, price, output ready);
endinterface

interface rmst_res_if;
    import rmst_pkg::*;
    logic                valid;
    logic                ready;
    logic [SPREAD_W-1:0] spread;
    logic                range_error;

    modport source (output valid, spread, range_error, input ready);
    modport sink   (input valid, spread, range_error, output ready);
endinterface

interface rmst_cfg_if;
    import rmst_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/rmst_node_mem.sv
// Node memory: per-node {min, max}, one write port and two registered read ports.
module rmst_node_mem #(
    parameter int AW = 11,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/rmst_ctrl.sv
// Sequencer: leaf-to-root repair for sets, bottom-up range walk for queries.
module rmst_ctrl #(
    parameter int MAX_ENTRIES = rmst_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = rmst_pkg::VALUE_BITS_DEF,
    parameter int AW          = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  rmst_pkg::t_cmd           i_cmd,
    input  logic [rmst_pkg::CFG_W-1:0] i_entries,
    // node memory
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic [2*VALUE_BITS-1:0]  o_wdata,
    output logic [AW-1:0]            o_raddr_a,
    output logic [AW-1:0]            o_raddr_b,
    input  logic [2*VALUE_BITS-1:0]  i_rdata_a,
    input  logic [2*VALUE_BITS-1:0]  i_rdata_b,
    // result side
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output rmst_pkg::t_result        o_res
);
    import rmst_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int LEAF_B = AW - 1;
    localparam int LEAVES = 2**LEAF_B;
    localparam int HW     = AW + 1;
    localparam int WW     = AW + INDEX_W + 2;
    localparam int PW     = (PRICE_W > VB) ? PRICE_W : VB;
    localparam int SW     = (SPREAD_W > VB) ? SPREAD_W : VB;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UP   = 3'd1;
    localparam logic [2:0] ST_QRY  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_node, n_node;
    logic [VB-1:0] r_cur_min, n_cur_min;
    logic [VB-1:0] r_cur_max, n_cur_max;
    logic [HW-1:0] r_lo, n_lo;
    logic [HW-1:0] r_hi, n_hi;
    logic          r_take_a, n_take_a;
    logic          r_take_b, n_take_b;
    logic [VB-1:0] r_mn, n_mn;
    logic [VB-1:0] r_mx, n_mx;
    logic          r_err, n_err;

    logic          accept;
    logic [WW-1:0] first_leaf;
    logic [WW-1:0] hi_start;
    logic [AW-1:0] leaf_addr;
    logic          set_ok;
    logic          qry_err;
    logic [PW-1:0] price_x;
    logic [VB-1:0] value;
    logic [AW-1:0] parent;
    logic [VB-1:0] up_min, up_max;
    logic [VB-1:0] a_min, a_max, b_min, b_max;
    logic [VB-1:0] fold_mn1, fold_mx1, fold_mn, fold_mx;
    logic [HW-1:0] hi_dec;
    logic [VB-1:0] diff;
    logic [SW-1:0] spread_x;

    // Request decode
    assign accept     = i_req_valid && o_req_ready;
    assign first_leaf = WW'(LEAVES) + WW'(i_cmd.first_index);
    assign hi_start   = WW'(LEAVES) + WW'(i_cmd.last_index) + WW'(1);
    assign leaf_addr  = first_leaf[AW-1:0];
    assign set_ok     = WW'(i_cmd.first_index) < WW'(MAX_ENTRIES);
    assign qry_err    = (i_cmd.first_index > i_cmd.last_index)
                     || (WW'(i_cmd.last_index) >= WW'(i_entries))
                     || (WW'(i_cmd.last_index) >= WW'(MAX_ENTRIES));
    assign price_x    = PW'(i_cmd.price);
    assign value      = price_x[VB-1:0];

    // Repair step: parent of the current node from it and its sibling
    assign parent = r_node >> 1;
    assign a_min  = i_rdata_a[2*VB-1:VB];
    assign a_max  = i_rdata_a[VB-1:0];
    assign b_min  = i_rdata_b[2*VB-1:VB];
    assign b_max  = i_rdata_b[VB-1:0];
    assign up_min = (a_min < r_cur_min) ? a_min : r_cur_min;
    assign up_max = (a_max > r_cur_max) ? a_max : r_cur_max;

    // Query fold of the nodes read last cycle
    assign fold_mn1 = (r_take_a && a_min < r_mn) ? a_min : r_mn;
    assign fold_mx1 = (r_take_a && a_max > r_mx) ? a_max : r_mx;
    assign fold_mn  = (r_take_b && b_min < fold_mn1) ? b_min : fold_mn1;
    assign fold_mx  = (r_take_b && b_max > fold_mx1) ? b_max : fold_mx1;
    assign hi_dec   = r_hi - HW'(1);

    // Final spread
    assign diff     = (r_err || r_mx < r_mn) ? '0 : (r_mx - r_mn);
    assign spread_x = SW'(diff);

    assign o_req_ready       = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_FIN);
    assign o_res.spread      = spread_x[SPREAD_W-1:0];
    assign o_res.range_error = r_err;

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_cur_min = r_cur_min;
        n_cur_max = r_cur_max;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_take_a  = 1'b0;
        n_take_b  = 1'b0;
        n_mn      = r_mn;
        n_mx      = r_mx;
        n_err     = r_err;
        o_we      = 1'b0;
        o_waddr   = leaf_addr;
        o_wdata   = {value, value};
        o_raddr_a = leaf_addr ^ AW'(1);
        o_raddr_b = leaf_addr;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.kind == KIND_SET) begin
                    if (set_ok) begin
                        o_we      = 1'b1;
                        n_node    = leaf_addr;
                        n_cur_min = value;
                        n_cur_max = value;
                        n_state   = ST_UP;
                    end
                end else if (accept) begin
                    n_err = qry_err;
                    n_lo  = first_leaf[HW-1:0];
                    n_hi  = hi_start[HW-1:0];
                    n_mn  = '1;
                    n_mx  = '0;
                    n_state = qry_err ? ST_FIN : ST_QRY;
                end
            end
            ST_UP: begin
                o_we      = 1'b1;
                o_waddr   = parent;
                o_wdata   = {up_min, up_max};
                o_raddr_a = parent ^ AW'(1);
                n_cur_min = up_min;
                n_cur_max = up_max;
                n_node    = parent;
                if (parent == AW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY: begin
                n_mn      = fold_mn;
                n_mx      = fold_mx;
                o_raddr_a = r_lo[AW-1:0];
                o_raddr_b = hi_dec[AW-1:0];
                if (r_lo < r_hi) begin
                    n_take_a = r_lo[0];
                    n_take_b = r_hi[0];
                    n_lo     = (r_lo + HW'(r_lo[0])) >> 1;
                    n_hi     = r_hi >> 1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_take_a <= 1'b0;
            r_take_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_take_a <= n_take_a;
            r_take_b <= n_take_b;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_cur_min <= n_cur_min;
        r_cur_max <= n_cur_max;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mn      <= n_mn;
        r_mx      <= n_mx;
        r_err     <= n_err;
    end

endmodule

### hw/rtl/range_min_max_spread_tree.sv
// Top level: range min/max spread tree with config register and result register.
//
// Channels: i_req takes requests (kind set or query, indices, price), i_cfg
// writes entries_in_use, o_res returns one result per query (none per set).
// All handshakes complete on a rising edge with valid and ready high.
// A set writes its leaf, then repairs one ancestor per cycle up to the root,
// reading each sibling on read port a of the node memory. A query walks the
// tree bottom-up, reading at most two nodes per level on the two read ports;
// an empty or out-of-range query skips the walk and flags range_error.
// One request is worked on at a time; i_req.ready is high while idle.
// The result sits in an output register; while the receiver stalls, the
// block still takes a set, but a query holds its result until the register
// frees. Reset clears the control state and sets entries_in_use to 1024;
// the node memory is not cleared, so entries must be set before a query.
module range_min_max_spread_tree #(
    parameter int MAX_ENTRIES = rmst_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = rmst_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_req_if.sink    i_req,
    rmst_cfg_if.sink    i_cfg,
    rmst_res_if.source  o_res
);
    import rmst_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES) + 1;
    localparam int DW = 2 * VALUE_BITS;

    logic [CFG_W-1:0] r_entries;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;
    t_cmd             cmd;
    t_result          res;
    logic             res_valid;
    logic             res_ready;
    logic             we;
    logic [AW-1:0]    waddr, raddr_a, raddr_b;
    logic [DW-1:0]    wdata, rdata_a, rdata_b;

    // Configuration register, always writable
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg.valid) begin
            r_entries <= i_cfg.data;
        end
    end

    assign cmd.kind        = i_req.kind;
    assign cmd.first_index = i_req.first_index;
    assign cmd.last_index  = i_req.last_index;
    assign cmd.price       = i_req.price;

    rmst_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_cmd       (cmd),
        .i_entries   (r_entries),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    rmst_node_mem #(
        .AW (AW),
        .DW (DW)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.spread      = r_out.spread;
    assign o_res.range_error = r_out.range_error;

endmodule

### tb/range_min_max_spread_tree_tb.sv
// Testbench for range_min_max_spread_tree: directed, bulk-load, random and backpressure tests.
module range_min_max_spread_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmst_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int unsigned TREE_ENTRIES   = MAX_ENTRIES_DEF;
    localparam int unsigned INDEX_MAX      = (1 << INDEX_W) - 1;
    localparam int unsigned VALUE_MASK     = (1 << VALUE_BITS_DEF) - 1;
    // Entries 0 .. LOADED_ENTRIES-1 are all written before random queries
    localparam int unsigned LOADED_ENTRIES = 512;
    // Longest request is a query plus the result register
    localparam int          SETTLE_CYCLES  = 32;
    localparam int          PHASE_REQUESTS = 42;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          WATCHDOG_LIMIT = 6000;

    logic i_clk   = 1'b0;
    logic i_rst_n;

    rmst_req_if req_if ();
    rmst_cfg_if cfg_if ();
    rmst_res_if res_if ();

    range_min_max_spread_tree uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the array and the entries-in-use register
    logic [VALUE_BITS_DEF-1:0] price_at [TREE_ENTRIES];
    logic [CFG_W-1:0]          entries_cfg = ENTRIES_RESET;

    t_result pending_spreads [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_results = 1'b0;

    int n_failures    = 0;
    int n_sets        = 0;
    int n_queries     = 0;
    int n_range_errs  = 0;
    int n_checked     = 0;
    int n_cfg_writes  = 0;
    int idle_cycles   = 0;

    // Entry count that queries may touch
    function automatic int unsigned usable_entries();
        return (entries_cfg > TREE_ENTRIES) ? TREE_ENTRIES : int'(entries_cfg);
    endfunction

    // Spread over [lo, hi] from the shadow array, or the error result
    function automatic t_result predict_spread(int unsigned lo, int unsigned hi);
        t_result     r;
        int unsigned mn;
        int unsigned mx;
        int unsigned k;
        r.spread      = '0;
        r.range_error = 1'b1;
        if (lo <= hi && hi < usable_entries()) begin
            mn = VALUE_MASK;
            mx = 0;
            for (k = lo; k <= hi; k++) begin
                if (price_at[k] < mn) mn = price_at[k];
                if (price_at[k] > mx) mx = price_at[k];
            end
            r.spread      = SPREAD_W'(mx - mn);
            r.range_error = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [PRICE_W-1:0] random_price();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PRICE_W'(VALUE_MASK);
            default: return PRICE_W'($urandom);
        endcase
    endfunction

    task automatic log_failure(string msg);
        n_failures++;
        if (n_failures <= 10) $display("%s", msg);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // Offer one request, starting and ending at a falling edge
    task automatic send_request(logic [KIND_W-1:0] kind, int unsigned lo, int unsigned hi,
                                logic [PRICE_W-1:0] price);
        t_result want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.first_index <= INDEX_W'(lo);
        req_if.last_index  <= INDEX_W'(hi);
        req_if.price       <= price;
        do @(posedge i_clk); while (!req_if.ready);
        if (kind == KIND_QUERY) begin
            want = predict_spread(lo, hi);
            pending_spreads.push_back(want);
            n_queries++;
            if (want.range_error) n_range_errs++;
        end else begin
            if (lo < TREE_ENTRIES) price_at[lo] = VALUE_BITS_DEF'(price);
            n_sets++;
        end
        @(negedge i_clk);
    endtask

    // Drop valid, wait for all results, then let any set finish its walk
    task automatic wait_until_quiet();
        req_if.valid <= 1'b0;
        while (pending_spreads.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_entries_in_use(int unsigned value);
        wait_until_quiet();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= CFG_W'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        entries_cfg = CFG_W'(value);
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // One random request shaped by the current entry count
    task automatic send_random_request();
        int unsigned eff;
        int unsigned span;
        int unsigned step;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        logic [KIND_W-1:0] kind;
        eff  = usable_entries();
        // valid ranges stay inside the loaded entries
        span = (eff < LOADED_ENTRIES) ? eff : LOADED_ENTRIES;
        pick = $urandom_range(0, 99);
        lo   = $urandom_range(0, INDEX_MAX);
        hi   = $urandom_range(0, INDEX_MAX);
        step = $urandom_range(0, 15);
        kind = KIND_QUERY;
        if (pick < 35) begin
            kind = KIND_SET;
        end else if (pick < 85 && span > 0) begin
            lo = $urandom_range(0, span - 1);
            case ($urandom_range(0, 7))
                0: hi = $urandom_range(lo, span - 1);
                1: begin
                    lo = 0;
                    hi = span - 1;
                end
                default: hi = (lo + step > span - 1) ? span - 1 : lo + step;
            endcase
            if (hi < lo) hi = lo;
        end else if (eff < TREE_ENTRIES && $urandom_range(0, 1) == 1) begin
            // out of bounds
            hi = $urandom_range(eff, INDEX_MAX);
        end else begin
            // empty range
            lo = $urandom_range(1, INDEX_MAX);
            hi = $urandom_range(0, lo - 1);
        end
        send_request(kind, lo, hi, random_price());
    endtask

    // Extremes of the fields, every request kind, register corner values
    task automatic test_directed_cases();
        set_idling(0, 0);
        // reset count of 1024 lets the top entries be queried
        send_request(KIND_SET, INDEX_MAX, 0, PRICE_W'(7));
        send_request(KIND_SET, INDEX_MAX - 1, INDEX_MAX, PRICE_W'(9));
        send_request(KIND_QUERY, INDEX_MAX - 1, INDEX_MAX, '0);
        send_request(KIND_QUERY, INDEX_MAX, INDEX_MAX - 1, '0);
        write_entries_in_use(2);
        send_request(KIND_SET, 0, INDEX_MAX, '0);
        send_request(KIND_SET, 1, 0, PRICE_W'(VALUE_MASK));
        send_request(KIND_QUERY, 0, 1, PRICE_W'(VALUE_MASK));
        send_request(KIND_QUERY, 0, 0, '0);
        send_request(KIND_QUERY, 1, 1, '0);
        send_request(KIND_QUERY, 0, 2, '0);
        send_request(KIND_QUERY, INDEX_MAX, INDEX_MAX, '0);
        // a set past the entries in use still lands in the array
        send_request(KIND_SET, 600, 0, PRICE_W'(5));
        write_entries_in_use(1);
        send_request(KIND_QUERY, 0, 0, '0);
        send_request(KIND_QUERY, 0, 1, '0);
        write_entries_in_use(0);
        send_request(KIND_QUERY, 0, 0, '0);
        // register above the tree size is clamped
        write_entries_in_use((1 << CFG_W) - 1);
        send_request(KIND_QUERY, INDEX_MAX - 1, INDEX_MAX, '0);
        send_request(KIND_QUERY, INDEX_MAX, INDEX_MAX, '0);
        send_request(KIND_QUERY, 600, 600, '0);
        write_entries_in_use(TREE_ENTRIES);
        send_request(KIND_QUERY, 0, 1, '0);
    endtask

    // Write the low entries so later queries never touch an unwritten leaf
    task automatic test_full_load();
        int unsigned k;
        set_idling(21, 21);
        for (k = 0; k < LOADED_ENTRIES; k++) send_request(KIND_SET, k, $urandom, random_price());
        send_request(KIND_QUERY, 0, LOADED_ENTRIES - 1, '0);
        send_request(KIND_QUERY, LOADED_ENTRIES - 1, LOADED_ENTRIES - 1, '0);
    endtask

    // Random sets and queries over several register values and idling modes
    task automatic test_random_traffic();
        int p;
        int n;
        int unsigned cfg_val;
        for (p = 0; p < 8; p++) begin
            case (p)
                0:       cfg_val = TREE_ENTRIES;
                1:       cfg_val = 1;
                2:       cfg_val = 2;
                3:       cfg_val = 513;
                4:       cfg_val = (1 << CFG_W) - 1;
                5:       cfg_val = 0;
                6:       cfg_val = $urandom_range(3, INDEX_MAX);
                default: cfg_val = TREE_ENTRIES;
            endcase
            write_entries_in_use(cfg_val);
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(56, 0);
                2:       set_idling(0, 56);
                default: set_idling(21, 21);
            endcase
            for (n = 0; n < PHASE_REQUESTS; n++) send_random_request();
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        int n;
        wait_until_quiet();
        set_idling(0, 0);
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results <= 1'b0;
            end
            begin
                for (n = 0; n < 24; n++) send_random_request();
            end
        join
    endtask

    // Result receiver with random stalls and the long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= !hold_results && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result with the oldest predicted spread
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_spreads.size() == 0) begin
                log_failure($sformatf("unexpected result: spread=%0d range_error=%0b",
                                      res_if.spread, res_if.range_error));
            end else begin
                want = pending_spreads.pop_front();
                n_checked++;
                if (res_if.spread !== want.spread || res_if.range_error !== want.range_error)
                    log_failure($sformatf(
                        "mismatch: spread exp=%0d got=%0d, range_error exp=%0b got=%0b",
                        want.spread, res_if.spread, want.range_error, res_if.range_error));
            end
        end
    end

    // Watchdog on cycles without any completed handshake
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("range_min_max_spread_tree_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_SET;
        req_if.first_index = '0;
        req_if.last_index  = '0;
        req_if.price       = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_load();
        test_random_traffic();
        test_output_backpressure();
        wait_until_quiet();

        if (pending_spreads.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_spreads.size()));
        $display("covered %0d sets and %0d queries (%0d range errors), %0d results checked,",
                 n_sets, n_queries, n_range_errs, n_checked);
        $display("over %0d register writes, four idling modes and one long output stall",
                 n_cfg_writes);
        if (n_failures == 0) begin
            $display("range_min_max_spread_tree_tb: clean");
        end else begin
            $display("%0d failures", n_failures);
            $display("range_min_max_spread_tree_tb: errors");
        end
        $finish;
    end

endmodule
